// ----- sv/kwm_pkg.sv -----
// Shared constants, payload types and control bundles for the k-way sorted merge.
package kwm_pkg;

  localparam int NUM_LISTS  = 4;
  localparam int LIST_DEPTH = 16;

  localparam int IDX_W  = $clog2(NUM_LISTS);
  localparam int USED_W = $clog2(NUM_LISTS + 1);
  localparam int PTR_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  localparam int LC_W    = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic       CMD_APPEND = 1'b0;
  localparam logic       CMD_CLOSE  = 1'b1;

  localparam logic [1:0] ST_ELEM   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [31:0] KEY_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic               command;
    logic [1:0]         list_index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] merged_value;
    logic [1:0]         source_list;
    logic               last_of_merge;
  } out_t;

  typedef struct packed {
    logic latch_in;
    logic apply;
    logic reject;
    logic scan_clear;
    logic scan_step;
    logic emit_finish;
    logic emit_elem;
  } kwm_cmd_t;

  typedef struct packed {
    logic reject;
    logic scan_last;
    logic ready;
    logic have;
    logic done;
    logic out_free;
  } kwm_stat_t;

endpackage

// ----- sv/kwm_ctrl.sv -----
// Sequencer for the merge: input intake, list scan rounds and result issue.
module kwm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kwm_pkg::kwm_stat_t stat,
  output kwm_pkg::kwm_cmd_t  cmd
);
  import kwm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPLY  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_APPLY;
        end
      end
      S_APPLY: begin
        if (stat.reject) begin
          // hold until the output register can take the rejection
          if (stat.out_free) begin
            cmd.reject     = 1'b1;
            cmd.scan_clear = 1'b1;
            state_next     = S_SCAN;
          end
        end else begin
          cmd.apply      = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.ready) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          if (!stat.have) begin
            cmd.emit_finish = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.emit_elem = 1'b1;
            if (stat.done) begin
              state_next = S_IDLE;
            end else begin
              cmd.scan_clear = 1'b1;
              state_next     = S_SCAN;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/kwm_dp.sv -----
// List buffers, head scan accumulator, list_count register and output register.
module kwm_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  kwm_pkg::in_t                in_item,
  input  kwm_pkg::kwm_cmd_t           cmd,
  output kwm_pkg::kwm_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kwm_pkg::out_t               out_item,
  input  logic                        cfg_we,
  input  logic [kwm_pkg::LC_W-1:0]    cfg_data,
  output logic [kwm_pkg::LC_W-1:0]    list_count
);
  import kwm_pkg::*;

  logic signed [31:0] store [NUM_LISTS][LIST_DEPTH];

  in_t              in_reg;
  logic [CNT_W-1:0] fill   [NUM_LISTS];
  logic [PTR_W-1:0] rdpos  [NUM_LISTS];
  logic             closed [NUM_LISTS];

  logic [IDX_W-1:0] idx, idx_d;
  logic             step_d;
  logic [31:0]      rd_data;
  logic             acc_ready, acc_have;
  logic [IDX_W-1:0] acc_best;
  logic [31:0]      acc_key;

  logic [USED_W-1:0] used;
  logic [IDX_W-1:0]  li;
  logic [PTR_W-1:0]  wr_pos;
  logic [PTR_W-1:0]  pop_pos;
  logic [31:0]       cand_key;
  logic              done;
  logic              out_free;

  always_comb begin
    if (list_count == '0) begin
      used = USED_W'(1);
    end else if (int'(list_count) > NUM_LISTS) begin
      used = USED_W'(NUM_LISTS);
    end else begin
      used = USED_W'(list_count);
    end
  end

  assign li = IDX_W'(in_reg.list_index);

  // write slot is head plus fill, wrapped once
  always_comb begin
    logic [PTR_W:0] sum;
    sum = (PTR_W + 1)'(rdpos[li]) + (PTR_W + 1)'(fill[li]);
    if (int'(sum) >= LIST_DEPTH) begin
      sum = sum - (PTR_W + 1)'(LIST_DEPTH);
    end
    wr_pos = sum[PTR_W-1:0];
  end

  always_comb begin
    if (int'(rdpos[acc_best]) == LIST_DEPTH - 1) begin
      pop_pos = '0;
    end else begin
      pop_pos = rdpos[acc_best] + PTR_W'(1);
    end
  end

  assign cand_key = rd_data ^ KEY_FLIP;

  // merge ends once every list in use is closed and would be empty after the pop
  always_comb begin
    done = 1'b1;
    for (int i = 0; i < NUM_LISTS; i++) begin
      if (i < int'(used)) begin
        if (!closed[i]) begin
          done = 1'b0;
        end
        if (!((fill[i] == '0) ||
              (IDX_W'(i) == acc_best && fill[i] == CNT_W'(1)))) begin
          done = 1'b0;
        end
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat.reject    = (int'(in_reg.list_index) >= int'(used)) || closed[li] ||
                     (in_reg.command == CMD_APPEND && int'(fill[li]) >= LIST_DEPTH);
    stat.scan_last = (int'(idx) == int'(used) - 1);
    stat.ready     = acc_ready;
    stat.have      = acc_have;
    stat.done      = done;
    stat.out_free  = out_free;
  end

  // buffer memory: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.apply && in_reg.command == CMD_APPEND) begin
      store[li][wr_pos] <= in_reg.value;
    end
    rd_data <= store[idx][rdpos[idx]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_reg <= in_item;
    end
    if (cmd.reject) begin
      out_item <= '{status: ST_REJECT, merged_value: '0,
                    source_list: in_reg.list_index, last_of_merge: 1'b0};
    end else if (cmd.emit_finish) begin
      out_item <= '{status: ST_FINISH, merged_value: '0,
                    source_list: '0, last_of_merge: 1'b1};
    end else if (cmd.emit_elem) begin
      out_item <= '{status: ST_ELEM, merged_value: $signed(acc_key ^ KEY_FLIP),
                    source_list: 2'(acc_best), last_of_merge: done};
    end
    if (step_d && fill[idx_d] != '0) begin
      if (!acc_have || cand_key < acc_key) begin
        acc_best <= idx_d;
        acc_key  <= cand_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_count <= LC_W'(4);
      out_valid  <= 1'b0;
      idx        <= '0;
      idx_d      <= '0;
      step_d     <= 1'b0;
      acc_ready  <= 1'b0;
      acc_have   <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill[i]   <= '0;
        rdpos[i]  <= '0;
        closed[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        list_count <= cfg_data;
      end

      if (cmd.reject || cmd.emit_finish || cmd.emit_elem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      step_d <= cmd.scan_step;
      idx_d  <= idx;
      if (cmd.scan_clear) begin
        idx <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + IDX_W'(1);
      end

      if (cmd.scan_clear) begin
        acc_ready <= 1'b1;
        acc_have  <= 1'b0;
      end else if (step_d) begin
        if (fill[idx_d] == '0) begin
          if (!closed[idx_d]) begin
            acc_ready <= 1'b0;
          end
        end else begin
          acc_have <= 1'b1;
        end
      end

      if (cmd.apply) begin
        if (in_reg.command == CMD_APPEND) begin
          fill[li] <= fill[li] + CNT_W'(1);
        end else begin
          closed[li] <= 1'b1;
        end
      end

      // reopen every list for the next merge, else pop the emitted head
      if (cmd.emit_finish || (cmd.emit_elem && done)) begin
        for (int i = 0; i < NUM_LISTS; i++) begin
          fill[i]   <= '0;
          rdpos[i]  <= '0;
          closed[i] <= 1'b0;
        end
      end else if (cmd.emit_elem) begin
        rdpos[acc_best] <= pop_pos;
        fill[acc_best]  <= fill[acc_best] - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/k_way_sorted_merge.sv -----
// Top level of the k-way sorted merge: APB register port, controller and datapath.
// Each input item appends a value to one list or closes it; items for a list not in use, closed
// or full are rejected. The block then emits the smallest list head (lowest list on ties) for as
// long as every list in use holds an element or is closed, marks the last element of a merge and
// reopens all lists; once all lists in use are closed and empty it emits a finish result. Each
// round (one result, or the finding that no result is due) reads the heads one list per cycle
// from the registered read port of the buffer memory and compares them against a running
// minimum. A finished result sits in an output register, so the next scan round runs while
// it waits to be taken.
module k_way_sorted_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  kwm_pkg::in_t                  in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output kwm_pkg::out_t                 out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kwm_pkg::PADDR_W-1:0]   paddr,
  input  logic [kwm_pkg::PDATA_W-1:0]   pwdata,
  output logic [kwm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import kwm_pkg::*;

  kwm_cmd_t        cmd;
  kwm_stat_t       stat;
  logic            cfg_we;
  logic [LC_W-1:0] list_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[PADDR_W-1];
  assign prdata = paddr[PADDR_W-1] ? '0 : PDATA_W'(list_count);

  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kwm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_data   (pwdata[LC_W-1:0]),
    .list_count (list_count)
  );

endmodule

// ----- sv/kwm_check.sv -----
// Port-level checks for the k-way sorted merge, bound to the top level.
module kwm_check (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input kwm_pkg::out_t out_item
);
  import kwm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before the first was applied");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_REJECT |->
      !out_item.last_of_merge && out_item.merged_value == 0)
    else $error("malformed rejection");

  a_finish_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_FINISH |->
      out_item.last_of_merge && out_item.merged_value == 0 && out_item.source_list == 0)
    else $error("malformed finish result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status == ST_ELEM || out_item.status == ST_REJECT ||
                  out_item.status == ST_FINISH)
    else $error("undefined status code");

endmodule

bind k_way_sorted_merge kwm_check u_kwm_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
